@@ sv/sliding_window_mean_defines.svh @@
// Assertion macros for the moving average block.
// Used by sliding_window_mean.sv; expects clk_i and rst_ni in scope.
`ifndef SLIDING_WINDOW_MEAN_DEFINES_SVH
`define SLIDING_WINDOW_MEAN_DEFINES_SVH

// same-cycle implication
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/swm_pkg.sv @@
// Shared types and constants for the moving average block.
// No dependencies; imported by swm_div and sliding_window_mean.
`default_nettype none

package swm_pkg;

  localparam int DATA_W        = 32;
  localparam int WIN_W         = 11;
  localparam int CNT_W         = 11;
  localparam int SUM_W         = 42;
  localparam int DEF_MAX_DEPTH = 1024;

  localparam logic [WIN_W-1:0]  RESET_WINDOW = WIN_W'(50);
  localparam logic [CNT_W-1:0]  COUNT_CAP    = '1;
  localparam logic [DATA_W-1:0] MEAN_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MEAN_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last;
  } swm_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mean;
    logic                     too_few;
  } swm_out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dividend;
    logic [WIN_W-1:0]        divisor;
    logic                    too_few;
  } swm_div_req_t;

endpackage

`default_nettype wire

@@ sv/swm_div.sv @@
// Radix-2 restoring divider: signed running sum over window length,
// truncated toward zero and saturated to 32 bits. Depends on swm_pkg.
`default_nettype none

module swm_div import swm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire swm_div_req_t req_i,
  output      logic         busy_o,
  output      logic         done_o,
  output      swm_out_t     res_o
);

  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0] dvd_q, dvd_d;
  logic [WIN_W-1:0] rem_q, rem_d;
  logic [WIN_W-1:0] dsr_q, dsr_d;
  logic             neg_q, neg_d;
  logic             few_q, few_d;

  logic [WIN_W:0]   trial;
  logic             ge;
  logic [SUM_W-1:0] mag;
  logic             pos_ovf, neg_ovf;
  logic [DATA_W-1:0] low_q;

  assign mag   = req_i.dividend[SUM_W-1] ? SUM_W'(-req_i.dividend) : SUM_W'(req_i.dividend);
  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    neg_d   = neg_q;
    few_d   = few_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          step_d  = '0;
          dvd_d   = mag;
          rem_d   = '0;
          dsr_d   = req_i.divisor;
          neg_d   = req_i.dividend[SUM_W-1];
          few_d   = req_i.too_few;
        end
      end
      ST_RUN: begin
        // remainder stays below the divisor, so the top trial bit drops out
        rem_d  = ge ? WIN_W'(trial - {1'b0, dsr_q}) : trial[WIN_W-1:0];
        dvd_d  = {dvd_q[SUM_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    neg_q  <= neg_d;
    few_q  <= few_d;
  end

  // quotient magnitude sits in dvd_q during the final state
  assign low_q   = dvd_q[DATA_W-1:0];
  assign pos_ovf = |dvd_q[SUM_W-1:DATA_W-1];
  assign neg_ovf = (|dvd_q[SUM_W-1:DATA_W]) || (dvd_q[DATA_W-1] && (|dvd_q[DATA_W-2:0]));

  always_comb begin
    res_o.too_few = few_q;
    if (few_q) begin
      res_o.mean = '0;
    end else if (neg_q) begin
      res_o.mean = neg_ovf ? MEAN_MIN : DATA_W'(-low_q);
    end else begin
      res_o.mean = pos_ovf ? MEAN_MAX : low_q;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_FIN);

endmodule

`default_nettype wire

@@ sv/sliding_window_mean.sv @@
// Moving average over a stream of signed Q16.16 samples.
// Throughput: one sample per cycle; a last-marked sample is held off while a result is pending.
// Result path: a last sample passes the ring read-modify-write stage, then the bit-serial divider,
// then saturation into the output register.
// Reset: pointer, count, sum and handshakes clear, window returns to 50; ring contents kept.
// Files: swm_pkg, swm_div, sliding_window_mean_defines.svh.
`default_nettype none
`include "sliding_window_mean_defines.svh"

module sliding_window_mean import swm_pkg::*; #(
  parameter int MAX_WINDOW_DEPTH = DEF_MAX_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [WIN_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire swm_in_t          in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      swm_out_t         out_data_o
);

  localparam int AW       = $clog2(MAX_WINDOW_DEPTH);
  localparam int MAX_CLIP = (MAX_WINDOW_DEPTH > 2047) ? 2047 : MAX_WINDOW_DEPTH;
  localparam int PW       = ((AW > WIN_W) ? AW : WIN_W) + 1;
  localparam int EXT_W    = SUM_W - DATA_W;

  logic [WIN_W-1:0]  win_cfg_q;
  logic [WIN_W-1:0]  eff_win;
  logic [AW-1:0]     wp_q, wp_d, wp_eff;
  logic [PW-1:0]     wp_inc;
  logic [CNT_W-1:0]  seen_q, seen_d, seen_inc;
  logic signed [SUM_W-1:0] sum_q, sum_d, sum_sub, sum_new;

  logic              in_acc;
  logic              s1_valid_q;
  logic [DATA_W-1:0] s1_sample_q;
  logic              s1_last_q;
  logic              s1_sub_q;
  logic              s1_few_q;
  logic [AW-1:0]     s1_addr_q;
  logic [WIN_W-1:0]  s1_win_q;

  logic [DATA_W-1:0] ring_q [MAX_WINDOW_DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              fwd_q;
  logic [DATA_W-1:0] fwd_data_q;
  logic [DATA_W-1:0] old_val;

  swm_div_req_t      div_req;
  logic              div_start, div_busy, div_done;
  swm_out_t          div_res;
  logic              out_valid_q;
  swm_out_t          out_q;

  always_comb begin
    if (win_cfg_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (32'(win_cfg_q) > MAX_CLIP) begin
      eff_win = WIN_W'(MAX_CLIP);
    end else begin
      eff_win = win_cfg_q;
    end
  end

  // a pointer left beyond a shrunk window restarts at the bottom
  assign wp_eff   = (PW'(wp_q) >= PW'(eff_win)) ? '0 : wp_q;
  assign wp_inc   = PW'(wp_eff) + PW'(1);
  assign seen_inc = (seen_q < COUNT_CAP) ? seen_q + CNT_W'(1) : seen_q;

  assign in_stall_o = in_data_i.last && ((s1_valid_q && s1_last_q) || div_busy || out_valid_q);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    wp_d   = wp_q;
    seen_d = seen_q;
    if (in_acc) begin
      if (in_data_i.last) begin
        wp_d   = '0;
        seen_d = '0;
      end else begin
        wp_d   = (wp_inc >= PW'(eff_win)) ? '0 : wp_inc[AW-1:0];
        seen_d = seen_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q  <= RESET_WINDOW;
      wp_q       <= '0;
      seen_q     <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_cfg_q <= cfg_wdata_i;
      end
      wp_q       <= wp_d;
      seen_q     <= seen_d;
      sum_q      <= sum_d;
      s1_valid_q <= in_acc;
      // same entry read now as the one written now: memory returns stale data
      fwd_q      <= in_acc && s1_valid_q && (s1_addr_q == wp_eff);
      if (div_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= in_data_i.sample;
      s1_last_q   <= in_data_i.last;
      s1_sub_q    <= (seen_q >= eff_win);
      s1_few_q    <= (seen_inc < eff_win);
      s1_addr_q   <= wp_eff;
      s1_win_q    <= eff_win;
    end
    fwd_data_q <= s1_sample_q;
    if (div_done) begin
      out_q <= div_res;
    end
  end

  // ring store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      ring_q[s1_addr_q] <= s1_sample_q;
    end
    if (in_acc) begin
      rd_data_q <= ring_q[wp_eff];
    end
  end

  assign old_val = fwd_q ? fwd_data_q : rd_data_q;
  assign sum_sub = s1_sub_q ? sum_q - {{EXT_W{old_val[DATA_W-1]}}, old_val} : sum_q;
  assign sum_new = sum_sub + {{EXT_W{s1_sample_q[DATA_W-1]}}, s1_sample_q};

  always_comb begin
    sum_d = sum_q;
    if (s1_valid_q) begin
      sum_d = s1_last_q ? '0 : sum_new;
    end
  end

  assign div_start        = s1_valid_q && s1_last_q;
  assign div_req.dividend = sum_new;
  assign div_req.divisor  = s1_win_q;
  assign div_req.too_few  = s1_few_q;

  swm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SWM_ASSERT_IMP(a_div_start_idle, div_start, !div_busy,
                  "divider started while busy")
  `SWM_ASSERT_IMP(a_out_no_overwrite, div_done, !out_valid_q,
                  "result arrived while previous transaction pending")
  `SWM_ASSERT_NXT(a_last_clears, in_acc && in_data_i.last, (wp_q == '0) && (seen_q == '0),
                  "stream state not cleared after last sample")
  `SWM_ASSERT_IMP(a_fwd_source, fwd_q, $past(s1_valid_q),
                  "forwarding without a write in the previous cycle")

endmodule

`default_nettype wire

@@ tb/sliding_window_mean_tb.sv @@
// Self-checking testbench for sliding_window_mean: streams of Q16.16 samples
// through the valid/stall ports, means checked against an in-bench predictor.
// Depends on swm_pkg and the sliding_window_mean RTL only.
module sliding_window_mean_tb;
  import swm_pkg::*;

  localparam int unsigned DRAIN_CYCLES    = 60;
  localparam int unsigned WATCHDOG_CYCLES = 1_000_000;
  localparam int unsigned RANDOM_ITEMS    = 1950;

  // Predictor of the moving average plus the queue of means still owed
  class mean_tracker;
    logic [DATA_W-1:0] ring [DEF_MAX_DEPTH];
    int unsigned       wr_ptr;
    int unsigned       seen;
    int unsigned       filled;   // entries [0, filled) have been written
    logic [SUM_W-1:0]  acc;
    logic [WIN_W-1:0]  win_reg;
    swm_out_t          pending_means[$];
    int unsigned       mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr     = 0;
      seen       = 0;
      filled     = 0;
      acc        = '0;
      win_reg    = RESET_WINDOW;
      mismatches = 0;
    endfunction

    function int unsigned span();
      int unsigned w;
      w = win_reg;
      if (w == 0) w = 1;
      if (w > DEF_MAX_DEPTH) w = DEF_MAX_DEPTH;
      return w;
    endfunction

    function void set_window(logic [WIN_W-1:0] v);
      win_reg = v;
    endfunction

    function int unsigned outstanding();
      return pending_means.size();
    endfunction

    function void take_sample(swm_in_t item);
      int unsigned w;
      longint      q;
      swm_out_t    res;
      w = span();
      if (wr_ptr >= w) wr_ptr = 0;
      if (seen >= w)
        acc = acc - {{(SUM_W-DATA_W){ring[wr_ptr][DATA_W-1]}}, ring[wr_ptr]};
      ring[wr_ptr] = item.sample;
      acc = acc + {{(SUM_W-DATA_W){item.sample[DATA_W-1]}}, item.sample};
      if (wr_ptr + 1 > filled) filled = wr_ptr + 1;
      wr_ptr = (wr_ptr + 1 >= w) ? 0 : wr_ptr + 1;
      if (seen < COUNT_CAP) seen++;
      if (!item.last) return;
      if (seen < w) begin
        res.mean    = '0;
        res.too_few = 1'b1;
      end else begin
        q = longint'($signed(acc)) / longint'(w);
        // only reachable after a window change: clamp to 32-bit range
        if (q > longint'($signed(MEAN_MAX))) q = longint'($signed(MEAN_MAX));
        if (q < longint'($signed(MEAN_MIN))) q = longint'($signed(MEAN_MIN));
        res.mean    = q[DATA_W-1:0];
        res.too_few = 1'b0;
      end
      pending_means.push_back(res);
      seen   = 0;
      wr_ptr = 0;
      acc    = '0;
    endfunction

    function void check_mean(swm_out_t got);
      swm_out_t want;
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mean=%0d too_few=%0b", got.mean, got.too_few);
      end else begin
        want = pending_means.pop_front();
        if (got.mean !== want.mean || got.too_few !== want.too_few) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mean=%0d too_few=%0b, got mean=%0d too_few=%0b",
                     want.mean, want.too_few, got.mean, got.too_few);
        end
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [WIN_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  swm_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  swm_out_t         out_data_o;

  mean_tracker tracker = new();
  bit          steady  = 1'b0;   // no idling on either side while set

  sliding_window_mean DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial forever #6 clk_i = ~clk_i;

  initial begin
    #(WATCHDOG_CYCLES * 12);
    $display("tb: failure");
    $finish;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return MEAN_MAX;
    if (r == 1) return MEAN_MIN;
    if (r == 2) return DATA_W'($signed($urandom_range(0, 16)) - 8);
    return $urandom();
  endfunction

  // receiver back-pressure
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || steady) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  = pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_mean(out_data_o);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [DATA_W-1:0] smp, logic lst);
    int unsigned gap;
    swm_in_t     item;
    gap          = steady ? 0 : pick_gap();
    item.sample  = smp;
    item.last    = lst;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_sample(item);
    @(negedge clk_i);
  endtask

  // window writes only once the block has gone quiet
  task automatic set_window(logic [WIN_W-1:0] v);
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_window(v);
  endtask

  task automatic run_stream(int unsigned len, bit with_change);
    int unsigned change_at;
    change_at = with_change ? $urandom_range(1, len - 1) : len;
    for (int unsigned i = 0; i < len; i++) begin
      // mid-stream change kept within entries already written
      if (i == change_at) set_window(WIN_W'($urandom_range(0, tracker.filled)));
      send_item(pick_sample(), i == len - 1);
    end
  endtask

  initial begin
    int unsigned      rand_items;
    int unsigned      phase;
    int unsigned      w;
    int unsigned      len;
    int unsigned      n_streams;
    int unsigned      r;
    bit               big;
    logic [WIN_W-1:0] win;

    rand_items = 0;
    phase      = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // window of zero behaves as one
    set_window(WIN_W'(0));
    send_item(MEAN_MAX, 1'b1);
    send_item(MEAN_MIN, 1'b1);
    send_item('0, 1'b1);
    send_item('1, 1'b1);

    // truncation toward zero, short stream, sliding window
    set_window(WIN_W'(3));
    send_item(-32'sd1, 1'b0);
    send_item(-32'sd2, 1'b0);
    send_item(-32'sd2, 1'b1);
    send_item(32'sd5, 1'b0);
    send_item(32'sd0, 1'b1);
    send_item(32'sd10, 1'b0);
    send_item(32'sd20, 1'b0);
    send_item(32'sd30, 1'b0);
    send_item(32'sd40, 1'b0);
    send_item(32'sd50, 1'b1);

    // shrinking the window mid-stream pushes the mean past either limit
    set_window(WIN_W'(2));
    send_item(MEAN_MAX, 1'b0);
    send_item(MEAN_MAX, 1'b0);
    set_window(WIN_W'(1));
    send_item(MEAN_MAX, 1'b1);
    set_window(WIN_W'(2));
    send_item(MEAN_MIN, 1'b0);
    send_item(MEAN_MIN, 1'b0);
    set_window(WIN_W'(1));
    send_item(MEAN_MIN, 1'b1);

    // oversized window is clamped to the store depth
    set_window('1);
    send_item(pick_sample(), 1'b1);

    while (rand_items < RANDOM_ITEMS) begin
      big    = (phase == 2);
      steady = ($urandom_range(0, 4) == 0);
      if (big) begin
        win = $urandom_range(0, 1) ? WIN_W'(DEF_MAX_DEPTH) : '1;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) win = WIN_W'(0);
        else if (r == 1) win = WIN_W'(1);
        else if (r == 2) win = RESET_WINDOW;
        else if (r == 3) win = WIN_W'($urandom_range(17, 40));
        else win = WIN_W'($urandom_range(2, 16));
      end
      set_window(win);
      n_streams = big ? 1 : $urandom_range(2, 8);
      repeat (n_streams) begin
        w = tracker.span();
        if (big) len = w + $urandom_range(0, 6);
        else len = $urandom_range((w > 2) ? w - 2 : 1, w + w / 2 + 3);
        run_stream(len, !big && len >= 2 && $urandom_range(0, 7) == 0);
        rand_items += len;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    steady     = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/swm_pkg.sv
sv/swm_div.sv
sv/sliding_window_mean.sv
tb/sliding_window_mean_tb.sv
